/* sv/u8vc_pkg.sv */
// types and constants shared by the utf-8 validator and chunk marker
package u8vc_pkg;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_STRAY      = 3'd1,
    ERR_OVERLONG   = 3'd2,
    ERR_LEAD_HIGH  = 3'd3,
    ERR_TRUNC      = 3'd4,
    ERR_BAD_SECOND = 3'd5,
    ERR_BAD_CONT   = 3'd6
  } err_code_t;

  localparam int unsigned REG_CHUNK_LEN = 0;
  localparam int unsigned ADDR_BITS     = 3;
  localparam int unsigned DATA_BITS     = 32;
  localparam int unsigned SIZE_BITS     = 16;
  localparam int unsigned TOTAL_BITS    = 32;

  localparam logic [SIZE_BITS-1:0] CHUNK_LEN_RESET = 16'd1;

  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] CONT_BASE   = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] LEAD2_MIN   = 8'hC0;
  localparam logic [7:0] OVERLONG_HI = 8'hC1;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;
  localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
  localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
  localparam logic [7:0] F0_SECOND_MIN = 8'h90;
  localparam logic [7:0] F4_SECOND_MAX = 8'h8F;

endpackage

/* sv/utf8_validate_and_chunk_top.sv */
// top level of the streaming utf-8 validator and chunk marker
// Takes one byte per transaction and returns one result per byte. A new byte is accepted in
// every cycle while results are taken; each byte passes an input register and then a result
// register, whose outputs hold the result until it is taken. The byte checks, the saturating
// offset and code point counters and the chunk fill compare all sit in the single stage
// between those two registers, which sets the rate of one byte per cycle. in_ready follows
// out_ready combinationally when both registers are full. chunk_len is written through the
// register port at byte address 0 and must only change while the block is idle.
module utf8_validate_and_chunk_top
  import u8vc_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned CHUNK_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_text,
  input  logic                  empty_text,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            byte_out,
  output logic                  code_point_done,
  output logic                  chunk_end,
  output logic                  last_out,
  output logic [2:0]            error_code,
  output logic [31:0]           error_offset,
  output logic [TOTAL_BITS-1:0] code_point_total
);

  localparam int unsigned CMP_W = ((CHUNK_BITS > SIZE_BITS) ? CHUNK_BITS : SIZE_BITS) + 1;

  logic [SIZE_BITS-1:0] chunk_len;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_empty;
  logic       advance;

  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] lead_offset, lead_offset_next;
  logic [1:0]             bytes_remaining, bytes_remaining_next;
  logic [1:0]             seq_position, seq_position_next;
  logic [7:0]             second_min, second_min_next;
  logic [7:0]             second_max, second_max_next;
  err_code_t              pending_error, pending_error_next;
  logic [OFFSET_BITS-1:0] pending_offset, pending_offset_next;
  logic                   error_latched, error_latched_next;
  logic [CHUNK_BITS-1:0]  chunk_fill, chunk_fill_next;
  logic [TOTAL_BITS-1:0]  point_count, point_count_next;

  logic            done, chunk, ok, closes;
  logic [CMP_W-1:0] fill_inc;
  logic [7:0]      res_byte;
  err_code_t       res_code;
  logic [31:0]     res_offset;
  logic [TOTAL_BITS-1:0] res_total;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_BITS-1:2] == (ADDR_BITS-2)'(REG_CHUNK_LEN)) ?
                  DATA_BITS'(chunk_len) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_len <= CHUNK_LEN_RESET;
    end else if (psel && penable && pwrite &&
                 paddr[ADDR_BITS-1:2] == (ADDR_BITS-2)'(REG_CHUNK_LEN)) begin
      chunk_len <= pwdata[SIZE_BITS-1:0];
    end
  end

  // input register
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_last  <= end_of_text;
      s1_empty <= empty_text;
    end
  end

  // per-byte check
  assign fill_inc = CMP_W'(chunk_fill) + CMP_W'(1);
  assign closes   = (fill_inc >= CMP_W'(chunk_len)) || (fill_inc == (CMP_W'(1) << CHUNK_BITS));

  always_comb begin
    byte_offset_next     = byte_offset;
    lead_offset_next     = lead_offset;
    bytes_remaining_next = bytes_remaining;
    seq_position_next    = seq_position;
    second_min_next      = second_min;
    second_max_next      = second_max;
    pending_error_next   = pending_error;
    pending_offset_next  = pending_offset;
    error_latched_next   = error_latched;
    chunk_fill_next      = chunk_fill;
    point_count_next     = point_count;
    done       = 1'b0;
    chunk      = 1'b0;
    ok         = 1'b1;
    res_byte   = s1_byte;
    res_code   = ERR_NONE;
    res_offset = '0;
    res_total  = '0;

    if (s1_empty) begin
      res_byte = '0;
      chunk    = 1'b1;
    end else begin
      if (!error_latched) begin
        if (bytes_remaining == 2'd0) begin
          second_min_next = CONT_BASE;
          second_max_next = CONT_MAX;
          case (s1_byte) inside
            [8'h00:ASCII_MAX]: begin
              done = 1'b1;
            end
            [CONT_BASE:CONT_MAX]: begin
              error_latched_next  = 1'b1;
              pending_error_next  = ERR_STRAY;
              pending_offset_next = byte_offset;
            end
            [LEAD2_MIN:OVERLONG_HI]: begin
              error_latched_next  = 1'b1;
              pending_error_next  = ERR_OVERLONG;
              pending_offset_next = byte_offset;
            end
            [LEAD4_MAX+8'd1:8'hFF]: begin
              error_latched_next  = 1'b1;
              pending_error_next  = ERR_LEAD_HIGH;
              pending_offset_next = byte_offset;
            end
            default: begin
              if (s1_byte == LEAD3_MIN) begin
                second_min_next = E0_SECOND_MIN;
              end else if (s1_byte == LEAD_ED) begin
                second_max_next = ED_SECOND_MAX;
              end else if (s1_byte == LEAD4_MIN) begin
                second_min_next = F0_SECOND_MIN;
              end else if (s1_byte == LEAD4_MAX) begin
                second_max_next = F4_SECOND_MAX;
              end
              if (s1_last) begin
                error_latched_next  = 1'b1;
                pending_error_next  = ERR_TRUNC;
                pending_offset_next = byte_offset;
              end else begin
                if (s1_byte <= LEAD2_MAX) begin
                  bytes_remaining_next = 2'd1;
                end else if (s1_byte <= LEAD3_MAX) begin
                  bytes_remaining_next = 2'd2;
                end else begin
                  bytes_remaining_next = 2'd3;
                end
                seq_position_next   = 2'd1;
                lead_offset_next    = byte_offset;
                pending_error_next  = ERR_NONE;
                pending_offset_next = '0;
              end
            end
          endcase
        end else begin
          if (seq_position == 2'd1) begin
            ok = (s1_byte >= second_min) && (s1_byte <= second_max);
          end else begin
            ok = (s1_byte & CONT_MASK) == CONT_BASE;
          end
          if (!ok && pending_error == ERR_NONE) begin
            pending_error_next  = (seq_position == 2'd1) ? ERR_BAD_SECOND : ERR_BAD_CONT;
            pending_offset_next = byte_offset;
          end
          bytes_remaining_next = bytes_remaining - 2'd1;
          seq_position_next    = seq_position + 2'd1;
          if (bytes_remaining_next == 2'd0) begin
            seq_position_next = 2'd0;
            if (pending_error_next != ERR_NONE) begin
              error_latched_next = 1'b1;
            end else begin
              done = 1'b1;
            end
          end else if (s1_last) begin
            error_latched_next  = 1'b1;
            pending_error_next  = ERR_TRUNC;
            pending_offset_next = lead_offset;
          end
        end
        if (error_latched_next) begin
          bytes_remaining_next = 2'd0;
          seq_position_next    = 2'd0;
        end
        if (done) begin
          if (point_count != '1) begin
            point_count_next = point_count + TOTAL_BITS'(1);
          end
          chunk           = closes;
          chunk_fill_next = closes ? '0 : CHUNK_BITS'(fill_inc);
        end
        if (s1_last && !error_latched_next) begin
          chunk = 1'b1;
        end
      end
      if (error_latched_next) begin
        res_code   = pending_error_next;
        res_offset = 32'(pending_offset_next);
      end
      res_total = point_count_next;
    end

    if (s1_empty || s1_last) begin
      byte_offset_next     = '0;
      lead_offset_next     = '0;
      bytes_remaining_next = 2'd0;
      seq_position_next    = 2'd0;
      second_min_next      = CONT_BASE;
      second_max_next      = CONT_MAX;
      pending_error_next   = ERR_NONE;
      pending_offset_next  = '0;
      error_latched_next   = 1'b0;
      chunk_fill_next      = '0;
      point_count_next     = '0;
    end else if (byte_offset != '1) begin
      byte_offset_next = byte_offset + OFFSET_BITS'(1);
    end
  end

  // text state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= '0;
      lead_offset     <= '0;
      bytes_remaining <= 2'd0;
      seq_position    <= 2'd0;
      second_min      <= CONT_BASE;
      second_max      <= CONT_MAX;
      pending_error   <= ERR_NONE;
      pending_offset  <= '0;
      error_latched   <= 1'b0;
      chunk_fill      <= '0;
      point_count     <= '0;
    end else if (advance) begin
      byte_offset     <= byte_offset_next;
      lead_offset     <= lead_offset_next;
      bytes_remaining <= bytes_remaining_next;
      seq_position    <= seq_position_next;
      second_min      <= second_min_next;
      second_max      <= second_max_next;
      pending_error   <= pending_error_next;
      pending_offset  <= pending_offset_next;
      error_latched   <= error_latched_next;
      chunk_fill      <= chunk_fill_next;
      point_count     <= point_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_out         <= res_byte;
      code_point_done  <= done;
      chunk_end        <= chunk;
      last_out         <= s1_last || s1_empty;
      error_code       <= res_code;
      error_offset     <= res_offset;
      code_point_total <= res_total;
    end
  end

endmodule

/* sv/u8vc_checker.sv */
// port-level checker for the utf-8 validator and its bind
module u8vc_checker
  import u8vc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  byte_out,
  input logic        code_point_done,
  input logic        chunk_end,
  input logic        last_out,
  input logic [2:0]  error_code,
  input logic [31:0] error_offset
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(error_code) &&
    $stable(error_offset) && $stable(chunk_end) && $stable(last_out))
    else $error("result changed while stalled");

  // a result that carries an error marks no code point and no chunk end
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> !code_point_done && !chunk_end)
    else $error("code point or chunk marked after error");

  // a clean final byte always closes the chunk
  a_last_chunk: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_out && error_code == ERR_NONE |-> chunk_end)
    else $error("clean text end without chunk end");

  // no error offset without an error
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_NONE |-> error_offset == 32'd0)
    else $error("error offset set without error");

endmodule

bind utf8_validate_and_chunk_top u8vc_checker u_u8vc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .byte_out        (byte_out),
  .code_point_done (code_point_done),
  .chunk_end       (chunk_end),
  .last_out        (last_out),
  .error_code      (error_code),
  .error_offset    (error_offset)
);
